[design/pmsfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pmsfa_pkg;

  localparam logic [7:0] HDR_B     = 8'h42;
  localparam logic [7:0] HDR_M     = 8'h4D;
  localparam logic [7:0] HDR_ZERO  = 8'h00;
  localparam logic [7:0] HDR_LEN   = 8'd28;

  localparam logic [4:0] POS_PM1_LO   = 5'd5;
  localparam logic [4:0] POS_PM25_LO  = 5'd7;
  localparam logic [4:0] POS_PM10_LO  = 5'd9;
  localparam logic [4:0] POS_COUNT_LO = 5'd17;
  localparam logic [4:0] POS_LAST     = 5'd31;

  localparam logic [15:0] PM_MAX_LINEAR = 16'd500;

  localparam int PROD_W = 14;  // (pm - x0) * slope stays below 2**14
  localparam int QUO_W  = 7;   // quotient never exceeds 99
  localparam int AQI_W  = 10;  // y0 + quotient + 9-bit offset <= 1011

  typedef enum logic [2:0] {
    CAT_GREEN  = 3'd0,
    CAT_YELLOW = 3'd1,
    CAT_ORANGE = 3'd2,
    CAT_RED    = 3'd3,
    CAT_PURPLE = 3'd4,
    CAT_MAROON = 3'd5
  } color_t;

  // One linear segment of the index curve
  typedef struct packed {
    logic       over;   // PM2.5 above the last breakpoint
    logic [8:0] x0;
    logic [8:0] y0;
    logic [6:0] slope;  // y1 - y0
    logic [7:0] span;   // x1 - x0
  } band_t;

  typedef struct packed {
    logic idle;
    logic done;
  } aqi_stat_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = HDR_B;
      2'd1:    b = HDR_M;
      2'd2:    b = HDR_ZERO;
      2'd3:    b = HDR_LEN;
      default: b = HDR_B;
    endcase
    return b;
  endfunction

  function automatic band_t band_of(input logic [15:0] pm);
    band_t r;
    r.over = 1'b0;
    if (pm <= 16'd12) begin
      r.x0 = 9'd0;   r.y0 = 9'd0;   r.slope = 7'd50; r.span = 8'd12;
    end else if (pm <= 16'd35) begin
      r.x0 = 9'd13;  r.y0 = 9'd51;  r.slope = 7'd49; r.span = 8'd22;
    end else if (pm <= 16'd55) begin
      r.x0 = 9'd35;  r.y0 = 9'd101; r.slope = 7'd49; r.span = 8'd20;
    end else if (pm <= 16'd150) begin
      r.x0 = 9'd55;  r.y0 = 9'd151; r.slope = 7'd49; r.span = 8'd95;
    end else if (pm <= 16'd250) begin
      r.x0 = 9'd150; r.y0 = 9'd201; r.slope = 7'd99; r.span = 8'd100;
    end else if (pm <= 16'd350) begin
      r.x0 = 9'd250; r.y0 = 9'd301; r.slope = 7'd99; r.span = 8'd100;
    end else begin
      r.x0 = 9'd350; r.y0 = 9'd401; r.slope = 7'd99; r.span = 8'd150;
      r.over = (pm > PM_MAX_LINEAR);
    end
    return r;
  endfunction

  function automatic color_t color_of(input logic [15:0] aqi);
    color_t c;
    if (aqi < 16'd51)       c = CAT_GREEN;
    else if (aqi < 16'd101) c = CAT_YELLOW;
    else if (aqi < 16'd151) c = CAT_ORANGE;
    else if (aqi < 16'd201) c = CAT_RED;
    else if (aqi < 16'd301) c = CAT_PURPLE;
    else                    c = CAT_MAROON;
    return c;
  endfunction

endpackage

`default_nettype wire

[design/pmsfa_frame.sv]
`timescale 1ns / 1ps
`default_nettype none

module pmsfa_frame (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        byte_vld,
  input  wire logic [7:0]  byte_in,
  output logic             frame_done,
  output logic [15:0]      pm1_hold,
  output logic [15:0]      pm25_hold,
  output logic [15:0]      pm10_hold,
  output logic [15:0]      count_hold
);
  import pmsfa_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  hi_r;
  logic [15:0] pm1_r, pm25_r, pm10_r, count_r;
  logic [15:0] word;
  logic        in_hdr;

  assign word   = {hi_r, byte_in};
  assign in_hdr = (pos_r[4:2] == 3'd0);

  always_comb begin
    pos_nxt = pos_r;
    if (byte_vld) begin
      if (in_hdr) begin
        // a stray 'B' restarts the hunt as byte 0 of a new frame
        if (byte_in == hdr_byte(pos_r[1:0])) pos_nxt = pos_r + 5'd1;
        else if (byte_in == HDR_B)           pos_nxt = 5'd1;
        else                                 pos_nxt = 5'd0;
      end else if (pos_r == POS_LAST) begin
        pos_nxt = 5'd0;
      end else begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 5'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld && !in_hdr) begin
      if (!pos_r[0]) begin
        hi_r <= byte_in;
      end else begin
        case (pos_r)
          POS_PM1_LO:   pm1_r   <= word;
          POS_PM25_LO:  pm25_r  <= word;
          POS_PM10_LO:  pm10_r  <= word;
          POS_COUNT_LO: count_r <= word;
          default: ;
        endcase
      end
    end
  end

  assign frame_done = byte_vld && (pos_r == POS_LAST);
  assign pm1_hold   = pm1_r;
  assign pm25_hold  = pm25_r;
  assign pm10_hold  = pm10_r;
  assign count_hold = count_r;

endmodule

`default_nettype wire

[design/pmsfa_aqi.sv]
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial index unit: shift-add multiply, then restoring divide by the
// segment span, one bit per cycle each; PM2.5 above 500 skips both.
module pmsfa_aqi (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                ack,
  input  wire logic [15:0]         pm25,
  input  wire logic [8:0]          offset,
  output pmsfa_pkg::aqi_stat_t     stat,
  output logic [15:0]              aqi,
  output pmsfa_pkg::color_t        color
);
  import pmsfa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [PROD_W-1:0]   mcand_r, mcand_nxt;
  logic [6:0]          mult_r, mult_nxt;
  logic [PROD_W-1:0]   num_r, num_nxt;
  logic [7:0]          rem_r, rem_nxt;
  logic [7:0]          span_r, span_nxt;
  logic [8:0]          y0_r, y0_nxt;
  logic [15:0]         aqi_r, aqi_nxt;
  color_t              color_r, color_nxt;

  band_t               band;
  logic [15:0]         diff;
  logic [8:0]          trial;
  logic                qbit;
  logic [AQI_W-1:0]    sum;

  assign band  = band_of(pm25);
  assign diff  = pm25 - {7'd0, band.x0};
  assign trial = {rem_r, num_r[PROD_W-1]};
  assign qbit  = (trial >= {1'b0, span_r});
  assign sum   = AQI_W'(y0_r) + AQI_W'(num_r[QUO_W-1:0]) + AQI_W'(offset);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    mcand_nxt = mcand_r;
    mult_nxt  = mult_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    span_nxt  = span_r;
    y0_nxt    = y0_r;
    aqi_nxt   = aqi_r;
    color_nxt = color_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (band.over) begin
            aqi_nxt   = pm25;
            color_nxt = CAT_MAROON;
            state_nxt = ST_DONE;
          end else begin
            prod_nxt  = '0;
            mcand_nxt = PROD_W'(diff[7:0]);
            mult_nxt  = band.slope;
            span_nxt  = band.span;
            y0_nxt    = band.y0;
            cnt_nxt   = 4'd0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mult_r[0]) prod_nxt = prod_r + mcand_r;
        mcand_nxt = {mcand_r[PROD_W-2:0], 1'b0};
        mult_nxt  = {1'b0, mult_r[6:1]};
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == 4'd6) begin
          cnt_nxt   = 4'd0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // dividend from the product, remainder starts at zero
        num_nxt   = prod_r;
        rem_nxt   = 8'd0;
        cnt_nxt   = 4'd0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = qbit ? 8'(trial - {1'b0, span_r}) : trial[7:0];
        num_nxt = {num_r[PROD_W-2:0], qbit};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(PROD_W - 1)) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        aqi_nxt   = 16'(sum);
        color_nxt = color_of(16'(sum));
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (ack) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      prod_r  <= prod_nxt;
      mcand_r <= mcand_nxt;
      mult_r  <= mult_nxt;
      num_r   <= num_nxt;
      rem_r   <= rem_nxt;
      span_r  <= span_nxt;
      y0_r    <= y0_nxt;
      aqi_r   <= aqi_nxt;
      color_r <= color_nxt;
    end
  end

  assign stat.idle = (state_r == ST_IDLE);
  assign stat.done = (state_r == ST_DONE);
  assign aqi       = aqi_r;
  assign color     = color_r;

endmodule

`default_nettype wire

[design/pm_sensor_frame_aqi.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake                Payload
// in       in   in_tvalid / in_tready    in_tdata[7:0]   rx_byte
// out      out  out_tvalid / out_tready  out_tdata[87:0] pm values, aqi, color
// cfg      in   cfg_valid / cfg_ready    cfg_data[8:0]   aqi_offset
//
// Bytes are taken one per cycle while in_tready is high. The transfer of
// byte 31 of a frame starts the serial index unit (7 multiply steps, a load
// step, 14 divide steps and a sum; all skipped when PM2.5 is above 500), and
// in_tready stays low until the result moves to the output register. A
// stalled output holds the result and the input. rst_n is synchronous; it
// clears the frame hunt, the offset and out_tvalid.
module pm_sensor_frame_aqi (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] pm1_value, [31:16] pm25_value, [47:32] pm10_value,
  // [63:48] small_particle_count, [79:64] aqi_value, [82:80] color_category
  output logic [87:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data    // [8:0] aqi_offset
);
  import pmsfa_pkg::*;

  logic        in_xfer;
  logic        frame_done;
  logic [15:0] pm1_hold, pm25_hold, pm10_hold, count_hold;
  aqi_stat_t   stat;
  logic [15:0] aqi;
  color_t      color;
  logic        ack;

  logic [8:0]  offset_r;
  logic        out_vld_r;
  logic [82:0] out_data_r;

  assign in_tready = stat.idle;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign ack       = stat.done && (!out_vld_r || out_tready);

  pmsfa_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_vld   (in_xfer),
    .byte_in    (in_tdata),
    .frame_done (frame_done),
    .pm1_hold   (pm1_hold),
    .pm25_hold  (pm25_hold),
    .pm10_hold  (pm10_hold),
    .count_hold (count_hold)
  );

  pmsfa_aqi u_aqi (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (frame_done),
    .ack    (ack),
    .pm25   (pm25_hold),
    .offset (offset_r),
    .stat   (stat),
    .aqi    (aqi),
    .color  (color)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 9'd0;
    end else if (cfg_valid && cfg_ready) begin
      offset_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ack) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // holds are stable here: input is stalled from frame end until ack
  always_ff @(posedge clk) begin
    if (ack) begin
      out_data_r <= {color, aqi, count_hold, pm10_hold, pm25_hold, pm1_hold};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_data_r};

endmodule

`default_nettype wire
